[src/sine_sample_generator_macros.svh]
// Assertion macros for the sine sample generator.
// Included by the top level; relies on nothing else.
`ifndef SINE_SAMPLE_GENERATOR_MACROS_SVH
`define SINE_SAMPLE_GENERATOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SSG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssg assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssg assertion failed");

`endif

[src/ssg_pkg.sv]
// Shared constants and types of the sine sample generator.
// No dependencies; every other file but the macro header refers to it by scoped names.
package ssg_pkg;

  localparam int PHASE_BITS  = 32;
  localparam int SAMPLE_BITS = 16;

  localparam int FRAME_W = 32;
  localparam int PINC_W  = 32;
  localparam int AMP_W   = 15;
  localparam int TURN_W  = 32;  // normalized turn fraction
  localparam int PROD_W  = FRAME_W + PINC_W;

  // Polynomial for sin(pi/2 * x), Q16
  localparam int X_W   = 17;
  localparam int T_W   = 16;
  localparam int P_W   = 17;
  localparam int S15_W = 15;
  localparam logic [P_W-1:0] SIN_A = P_W'(102944);
  localparam logic [T_W-1:0] SIN_B = T_W'(42048);
  localparam logic [12:0]    SIN_C = 13'd4640;
  localparam logic [S15_W-1:0] S15_MAX = {S15_W{1'b1}};

  // Pipeline stage indexes
  localparam int NUM_STAGES = 6;
  localparam int ST_PHASE   = 0;
  localparam int ST_SQUARE  = 1;
  localparam int ST_TERM    = 2;
  localparam int ST_POLY    = 3;
  localparam int ST_SINE    = 4;
  localparam int ST_SCALE   = 5;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  // Register map
  localparam int ADDR_W = 3;
  localparam logic REG_PHASE_INC = 1'b0;
  localparam logic REG_AMPLITUDE = 1'b1;

  typedef struct packed {
    logic [PINC_W-1:0] phase_increment;
    logic [AMP_W-1:0]  amplitude;
  } cfg_t;

endpackage

[src/ssg_frame_if.sv]
// Request channel carrying one frame index per request.
// Depends on ssg_pkg for the field width.
interface ssg_frame_if;
  logic                        valid;
  logic                        ready;
  logic [ssg_pkg::FRAME_W-1:0] frame_index;

  modport source (output valid, output frame_index, input ready);
  modport sink   (input valid, input frame_index, output ready);
endinterface

[src/ssg_sample_if.sv]
// Request channel carrying one signed audio sample per request.
// Depends on ssg_pkg for the sample width.
interface ssg_sample_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ssg_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

[src/ssg_apb_regs.sv]
// APB register file: phase increment and amplitude.
// Depends on ssg_pkg for the register map and the cfg_t type.
module ssg_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssg_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output ssg_pkg::cfg_t               cfg_o
);

  ssg_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic          reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];  // byte offset 4*i, low bits ignored

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        ssg_pkg::REG_PHASE_INC: cfg_d.phase_increment = pwdata[ssg_pkg::PINC_W-1:0];
        ssg_pkg::REG_AMPLITUDE: cfg_d.amplitude       = pwdata[ssg_pkg::AMP_W-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      ssg_pkg::REG_PHASE_INC: prdata = 32'(cfg_q.phase_increment);
      ssg_pkg::REG_AMPLITUDE: prdata = 32'(cfg_q.amplitude);
      default:                prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[src/ssg_phase.sv]
// Phase stage: frame index times phase increment, normalized to a turn fraction.
// Depends on ssg_pkg.
module ssg_phase (
  input  logic                         clk_i,
  input  ssg_pkg::stage_en_t           en_i,
  input  logic [ssg_pkg::FRAME_W-1:0]  frame_index_i,
  input  logic [ssg_pkg::PINC_W-1:0]   phase_inc_i,
  output logic [ssg_pkg::TURN_W-1:0]   turn_o
);

  logic [ssg_pkg::PROD_W-1:0] prod;
  logic [ssg_pkg::PROD_W-1:0] prod_aligned;
  logic [ssg_pkg::TURN_W-1:0] turn_q;

  assign prod = ssg_pkg::PROD_W'(frame_index_i) * ssg_pkg::PROD_W'(phase_inc_i);
  // Drop bits above the phase width, then take the top of the word as the turn.
  assign prod_aligned = prod << (ssg_pkg::PROD_W - ssg_pkg::PHASE_BITS);

  always_ff @(posedge clk_i) begin
    if (en_i[ssg_pkg::ST_PHASE]) begin
      turn_q <= prod_aligned[ssg_pkg::PROD_W-1 -: ssg_pkg::TURN_W];
    end
  end

  assign turn_o = turn_q;

endmodule

[src/ssg_poly.sv]
// Quarter-wave sine polynomial over four pipeline stages, one multiply each.
// Depends on ssg_pkg.
module ssg_poly (
  input  logic                          clk_i,
  input  ssg_pkg::stage_en_t            en_i,
  input  logic [ssg_pkg::TURN_W-1:0]    turn_i,
  output logic [ssg_pkg::S15_W-1:0]     mag_o,
  output logic                          neg_o
);

  localparam int XX_W = 2 * ssg_pkg::X_W;

  // stage: square
  logic [1:0]                  quad;
  logic [15:0]                 frac;
  logic [ssg_pkg::X_W-1:0]     x_arg;
  logic [XX_W-1:0]             xx;
  logic [ssg_pkg::X_W-1:0]     x1_q, x2a_q;
  logic                        neg1_q;

  // stage: inner term
  logic [29:0]                 cx2;
  logic [ssg_pkg::T_W-1:0]     t_d;
  logic [ssg_pkg::X_W-1:0]     x2_q, x2b_q;
  logic [ssg_pkg::T_W-1:0]     t_q;
  logic                        neg2_q;

  // stage: outer term
  logic [32:0]                 x2t;
  logic [ssg_pkg::P_W-1:0]     p_d;
  logic [ssg_pkg::X_W-1:0]     x3_q;
  logic [ssg_pkg::P_W-1:0]     p_q;
  logic                        neg3_q;

  // stage: final product and Q15 rounding
  logic [XX_W-1:0]             xp;
  logic [17:0]                 s16;
  logic [17:0]                 s15_wide;
  logic [ssg_pkg::S15_W-1:0]   s15_d;
  logic [ssg_pkg::S15_W-1:0]   s15_q;
  logic                        neg4_q;

  assign quad  = turn_i[31:30];
  assign frac  = turn_i[29:14];
  // Odd quadrants run the quarter wave backwards.
  assign x_arg = quad[0] ? (ssg_pkg::X_W'(17'h10000) - ssg_pkg::X_W'(frac))
                         : ssg_pkg::X_W'(frac);
  assign xx    = XX_W'(x_arg) * XX_W'(x_arg) + XX_W'(32768);

  always_ff @(posedge clk_i) begin
    if (en_i[ssg_pkg::ST_SQUARE]) begin
      x1_q   <= x_arg;
      x2a_q  <= xx[16 +: ssg_pkg::X_W];
      neg1_q <= quad[1];
    end
  end

  assign cx2 = 30'(ssg_pkg::SIN_C) * 30'(x2a_q) + 30'(32768);
  assign t_d = ssg_pkg::SIN_B - ssg_pkg::T_W'(cx2[29:16]);

  always_ff @(posedge clk_i) begin
    if (en_i[ssg_pkg::ST_TERM]) begin
      x2_q   <= x1_q;
      x2b_q  <= x2a_q;
      t_q    <= t_d;
      neg2_q <= neg1_q;
    end
  end

  assign x2t = 33'(x2b_q) * 33'(t_q) + 33'(32768);
  assign p_d = ssg_pkg::SIN_A - ssg_pkg::P_W'(x2t[32:16]);

  always_ff @(posedge clk_i) begin
    if (en_i[ssg_pkg::ST_POLY]) begin
      x3_q   <= x2_q;
      p_q    <= p_d;
      neg3_q <= neg2_q;
    end
  end

  assign xp       = XX_W'(x3_q) * XX_W'(p_q) + XX_W'(32768);
  assign s16      = xp[XX_W-1:16];
  assign s15_wide = (s16 + 18'd1) >> 1;
  assign s15_d    = (s15_wide > 18'(ssg_pkg::S15_MAX)) ? ssg_pkg::S15_MAX
                                                       : s15_wide[ssg_pkg::S15_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i[ssg_pkg::ST_SINE]) begin
      s15_q  <= s15_d;
      neg4_q <= neg3_q;
    end
  end

  assign mag_o = s15_q;
  assign neg_o = neg4_q;

endmodule

[src/ssg_scale.sv]
// Gain stage: amplitude times sine magnitude, rounded, signed and saturated.
// Depends on ssg_pkg; holds the output register.
module ssg_scale (
  input  logic                                   clk_i,
  input  ssg_pkg::stage_en_t                     en_i,
  input  logic [ssg_pkg::AMP_W-1:0]              amplitude_i,
  input  logic [ssg_pkg::S15_W-1:0]              mag_i,
  input  logic                                   neg_i,
  output logic signed [ssg_pkg::SAMPLE_BITS-1:0] sample_o
);

  localparam int M_W    = ssg_pkg::AMP_W + ssg_pkg::S15_W + 1;
  localparam int RSHIFT = 31 - ssg_pkg::SAMPLE_BITS;
  localparam logic [M_W-1:0] HALF    = M_W'(1) << (RSHIFT - 1);
  localparam logic [M_W-1:0] POS_LIM = (M_W'(1) << (ssg_pkg::SAMPLE_BITS - 1)) - M_W'(1);
  localparam logic [M_W-1:0] NEG_LIM = M_W'(1) << (ssg_pkg::SAMPLE_BITS - 1);
  localparam logic [ssg_pkg::SAMPLE_BITS-1:0] S_MAX = POS_LIM[ssg_pkg::SAMPLE_BITS-1:0];
  localparam logic [ssg_pkg::SAMPLE_BITS-1:0] S_MIN = NEG_LIM[ssg_pkg::SAMPLE_BITS-1:0];

  logic [M_W-1:0]                  prod;
  logic [M_W-1:0]                  mag_rnd;
  logic [ssg_pkg::SAMPLE_BITS-1:0] mag_trunc;
  logic [ssg_pkg::SAMPLE_BITS-1:0] sample_d;
  logic [ssg_pkg::SAMPLE_BITS-1:0] sample_q;

  assign prod      = M_W'(amplitude_i) * M_W'(mag_i);
  // Round half away from zero on the magnitude, sign applied afterwards.
  assign mag_rnd   = (prod + HALF) >> RSHIFT;
  assign mag_trunc = mag_rnd[ssg_pkg::SAMPLE_BITS-1:0];

  always_comb begin
    if (neg_i) begin
      sample_d = (mag_rnd > NEG_LIM) ? S_MIN : (~mag_trunc + 1'b1);
    end else begin
      sample_d = (mag_rnd > POS_LIM) ? S_MAX : mag_trunc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ssg_pkg::ST_SCALE]) begin
      sample_q <= sample_d;
    end
  end

  assign sample_o = $signed(sample_q);

endmodule

[src/sine_sample_generator.sv]
// Sine sample generator (direct digital synthesis).
// Frame channel: each request carries an absolute frame index. Sample
// channel: each request returns amplitude * sin(2*pi*frame*inc / 2^32)
// as a signed Q1.15 sample, rounded and saturated, in request order.
// Configuration: APB port, phase increment at 0x0, amplitude at 0x4.
// Write only while no requests are in flight; pready is tied high.
// Pipeline: a frame passes through six register stages in order (phase
// multiply, x^2, inner term, outer term, sine, gain) that each hold one
// multiplier. Throughput: one request per cycle while the sample receiver is ready.
// Stalls: each stage holds when it is full and the one after it cannot
// move; empty stages keep filling, so frame ready drops only when all six
// stages hold data and the sample receiver is not ready.
// Reset: clears all stage valid bits and both registers to zero, which
// gives silent output until the amplitude is written.
// Depends on ssg_pkg, the channel interfaces, the stage modules and the
// assertion macro header.
`include "sine_sample_generator_macros.svh"

module sine_sample_generator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ssg_frame_if.sink                   frame_if,
  ssg_sample_if.source                sample_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssg_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  ssg_pkg::cfg_t                   cfg;
  ssg_pkg::stage_en_t              stage_en;
  logic [ssg_pkg::NUM_STAGES-1:0]  valid_q, valid_d;
  logic [ssg_pkg::TURN_W-1:0]      turn;
  logic [ssg_pkg::S15_W-1:0]       sine_mag;
  logic                            sine_neg;
  logic                            frame_acc;

  ssg_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage k loads when it is empty or its content moves on; the last stage
  // moves on when the receiver takes the sample.
  always_comb begin
    stage_en[ssg_pkg::NUM_STAGES-1] = !valid_q[ssg_pkg::NUM_STAGES-1] || sample_if.ready;
    for (int k = ssg_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  assign frame_if.ready = stage_en[ssg_pkg::ST_PHASE];
  assign frame_acc      = frame_if.valid && frame_if.ready;

  always_comb begin
    valid_d = valid_q;
    if (stage_en[0]) begin
      valid_d[0] = frame_if.valid;
    end
    for (int k = 1; k < ssg_pkg::NUM_STAGES; k++) begin
      if (stage_en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  ssg_phase u_phase (
    .clk_i         (clk_i),
    .en_i          (stage_en),
    .frame_index_i (frame_if.frame_index),
    .phase_inc_i   (cfg.phase_increment),
    .turn_o        (turn)
  );

  ssg_poly u_poly (
    .clk_i  (clk_i),
    .en_i   (stage_en),
    .turn_i (turn),
    .mag_o  (sine_mag),
    .neg_o  (sine_neg)
  );

  ssg_scale u_scale (
    .clk_i       (clk_i),
    .en_i        (stage_en),
    .amplitude_i (cfg.amplitude),
    .mag_i       (sine_mag),
    .neg_i       (sine_neg),
    .sample_o    (sample_if.sample)
  );

  assign sample_if.valid = valid_q[ssg_pkg::NUM_STAGES-1];

  // An accepted frame always lands in the first stage.
  `SSG_ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, frame_acc, valid_q[ssg_pkg::ST_PHASE])

  // Ready is withheld only when every stage is full and the output stalls.
  `SSG_ASSERT_NOW(a_ready_only_full, clk_i, rst_ni, !frame_if.ready, (&valid_q) && !sample_if.ready)

  // Zero gain must give silence.
  `SSG_ASSERT_NOW(a_zero_gain, clk_i, rst_ni, sample_if.valid && (cfg.amplitude == '0), sample_if.sample == '0)

  // Magnitudes never exceed full scale, so the most negative code never shows.
  `SSG_ASSERT_NOW(a_no_min_code, clk_i, rst_ni, sample_if.valid, sample_if.sample != {1'b1, {(ssg_pkg::SAMPLE_BITS-1){1'b0}}})

endmodule
